@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/nps_pkg.sv @@
package nps_pkg;

   localparam int STACK_DEPTH_DEFAULT = 16;

   localparam int CMD_W   = 2;
   localparam int NOTE_W  = 7;
   localparam int COUNT_W = 5;

   typedef logic [CMD_W-1:0]  cmd_type;
   typedef logic [NOTE_W-1:0] note_type;

   localparam cmd_type CMD_PUSH  = 2'd0;
   localparam cmd_type CMD_ERASE = 2'd1;
   localparam cmd_type CMD_POP   = 2'd2;

   typedef struct packed {
      note_type velocity;
      note_type note;
   } slot_type;

   localparam int REQ_W = 16;
   localparam int RSP_W = 40;

endpackage

@@ rtl/note_priority_stack_core.sv @@
// Push, no-op and empty pop or erase pass IDLE, TOP_RD, TOP_WAIT and RESP; pop adds
// POP_RD and POP_WAIT, erase the SCAN and SHIFT walks, from request beat to response beat.
// One request at a time is taken, the next only after RESP; the slot RAM walk
// bounds erase, and a stalled response holds the next one in RESP.
// Reset clears the fill count, the sequencer and the response valid;
// slot RAM contents are not cleared and only slots below the fill count are used.
`include "assert_macros.svh"

module note_priority_stack_core
   import nps_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // command[1:0], note[8:2], velocity[15:9]
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // popped_note[6:0], popped_velocity[13:7], top_note[20:14], top_velocity[27:21],
   // held_count[32:28], push_dropped[33], zero pad[39:34]
   output logic [RSP_W-1:0] rsp_tdata
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int SW = $bits(slot_type);

   typedef enum logic [3:0] {
      IDLE, POP_RD, POP_WAIT, SCAN_RD, SCAN_CMP, SHIFT_RD, SHIFT_WR,
      TOP_RD, TOP_WAIT, RESP
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      fill_ff, fill_in;
   logic [AW-1:0]      idx_ff, idx_in;
   note_type           note_ff, note_in;
   note_type           pop_note_ff, pop_note_in;
   note_type           pop_vel_ff, pop_vel_in;
   note_type           top_note_ff, top_note_in;
   note_type           top_vel_ff, top_vel_in;
   logic               drop_ff, drop_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_W-1:0]   rsp_tdata_ff, rsp_tdata_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   slot_type           wr_slot;
   logic [AW-1:0]      rd_addr;
   logic [SW-1:0]      rd_data;
   slot_type           rd_slot;

   logic               req_fire;
   logic               push_fire;
   cmd_type            req_cmd;
   note_type           req_note;
   note_type           req_vel;
   logic [AW-1:0]      fill_last;
   logic               fill_full;
   logic [CW-1:0]      idx_succ;

   assign req_cmd   = req_tdata[1:0];
   assign req_note  = req_tdata[8:2];
   assign req_vel   = req_tdata[15:9];
   assign req_tready = (state_ff == IDLE);
   assign req_fire  = req_tvalid && req_tready;
   assign fill_last = AW'(fill_ff - CW'(1));
   assign fill_full = (fill_ff == CW'(STACK_DEPTH));
   assign idx_succ  = CW'(idx_ff) + CW'(1);
   assign rd_slot   = slot_type'(rd_data);
   assign push_fire = req_fire && req_cmd == CMD_PUSH && req_note != '0 && !fill_full;

   nps_ram #(
      .WIDTH(SW),
      .DEPTH(STACK_DEPTH)
   ) u_slots (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_slot),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      idx_in        = idx_ff;
      note_in       = note_ff;
      pop_note_in   = pop_note_ff;
      pop_vel_in    = pop_vel_ff;
      top_note_in   = top_note_ff;
      top_vel_in    = top_vel_ff;
      drop_in       = drop_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_slot       = rd_slot;
      rd_addr       = idx_ff;

      case (state_ff)
         IDLE: begin
            if (req_fire) begin
               note_in     = req_note;
               pop_note_in = '0;
               pop_vel_in  = '0;
               drop_in     = 1'b0;
               idx_in      = '0;
               state_in    = TOP_RD;
               case (req_cmd)
                  CMD_PUSH: begin
                     if (req_note != '0) begin
                        if (fill_full) begin
                           drop_in = 1'b1;
                        end else begin
                           wr_en        = 1'b1;
                           wr_addr      = AW'(fill_ff);
                           wr_slot.note = req_note;
                           wr_slot.velocity = req_vel;
                           fill_in      = fill_ff + CW'(1);
                        end
                     end
                  end
                  CMD_ERASE: begin
                     if (fill_ff != '0) state_in = SCAN_RD;
                  end
                  CMD_POP: begin
                     if (fill_ff != '0) state_in = POP_RD;
                  end
                  default: state_in = TOP_RD;
               endcase
            end
         end
         POP_RD: begin
            rd_addr  = fill_last;
            state_in = POP_WAIT;
         end
         POP_WAIT: begin
            pop_note_in = rd_slot.note;
            pop_vel_in  = rd_slot.velocity;
            fill_in     = fill_ff - CW'(1);
            state_in    = TOP_RD;
         end
         SCAN_RD: begin
            rd_addr  = idx_ff;
            state_in = SCAN_CMP;
         end
         SCAN_CMP: begin
            if (rd_slot.note == note_ff) begin
               state_in = SHIFT_RD;
            end else if (idx_ff == fill_last) begin
               state_in = TOP_RD;
            end else begin
               idx_in   = idx_ff + AW'(1);
               state_in = SCAN_RD;
            end
         end
         SHIFT_RD: begin
            if (idx_succ == fill_ff) begin
               fill_in  = fill_ff - CW'(1);
               state_in = TOP_RD;
            end else begin
               rd_addr  = AW'(idx_succ);
               state_in = SHIFT_WR;
            end
         end
         SHIFT_WR: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_slot  = rd_slot;
            idx_in   = idx_ff + AW'(1);
            state_in = SHIFT_RD;
         end
         TOP_RD: begin
            rd_addr  = fill_last;
            state_in = TOP_WAIT;
         end
         TOP_WAIT: begin
            top_note_in = (fill_ff == '0) ? '0 : rd_slot.note;
            top_vel_in  = (fill_ff == '0) ? '0 : rd_slot.velocity;
            state_in    = RESP;
         end
         RESP: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {6'd0, drop_ff, COUNT_W'(fill_ff), top_vel_ff,
                                top_note_ff, pop_vel_ff, pop_note_ff};
               state_in      = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         fill_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      idx_ff       <= idx_in;
      note_ff      <= note_in;
      pop_note_ff  <= pop_note_in;
      pop_vel_ff   <= pop_vel_in;
      top_note_ff  <= top_note_in;
      top_vel_ff   <= top_vel_in;
      drop_ff      <= drop_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   `ASSERT_IMPL(a_fill_bound, clock, reset, 1'b1, fill_ff <= CW'(STACK_DEPTH))
   `ASSERT_NEXT(a_push_grows, clock, reset, push_fire, fill_ff == $past(fill_ff) + CW'(1))
   `ASSERT_IMPL(a_drop_no_pop, clock, reset, rsp_tvalid_ff && rsp_tdata_ff[33], rsp_tdata_ff[13:0] == '0)

endmodule

@@ rtl/nps_ram.sv @@
module nps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ verif/tb_note_priority_stack_core.sv @@
`timescale 1ns / 1ps

module tb_note_priority_stack_core;
   import nps_pkg::*;

   localparam int DEPTH       = STACK_DEPTH_DEFAULT;
   localparam int ITEMS       = 1650;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE      = 4 * DEPTH + 20;
   localparam int MAX_REPORTS = 10;

   localparam cmd_type CMD_NOP = 2'd3;

   typedef struct packed {
      logic               push_dropped;
      logic [COUNT_W-1:0] held_count;
      note_type           top_velocity;
      note_type           top_note;
      note_type           popped_velocity;
      note_type           popped_note;
   } stack_report_t;

   localparam int REPORT_W = $bits(stack_report_t);

   typedef struct {
      cmd_type       cmd;
      note_type      note;
      note_type      velocity;
      int            rep;
      bit            typed;
      stack_report_t report;
   } directed_row_t;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   // command[1:0], note[8:2], velocity[15:9]
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   // popped_note[6:0], popped_velocity[13:7], top_note[20:14], top_velocity[27:21],
   // held_count[32:28], push_dropped[33], zero pad[39:34]
   logic [RSP_W-1:0] rsp_tdata;

   note_type        held_notes [DEPTH];
   note_type        held_vels  [DEPTH];
   int              held_level = 0;
   stack_report_t   expected_reports [$];
   directed_row_t   directed_rows [$];
   int              mismatch_count = 0;
   int              cycle_count    = 0;
   int              send_idle_pct  = 0;
   int              recv_stall_pct = 0;
   bit              filling        = 1'b1;

   note_priority_stack_core #(
      .STACK_DEPTH(DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic stack_report_t make_report(int pn, int pv, int tn, int tv, int cnt,
                                                 int drop);
      stack_report_t r;
      r.popped_note     = note_type'(pn);
      r.popped_velocity = note_type'(pv);
      r.top_note        = note_type'(tn);
      r.top_velocity    = note_type'(tv);
      r.held_count      = COUNT_W'(cnt);
      r.push_dropped    = drop[0];
      return r;
   endfunction

   function automatic string show(stack_report_t r);
      return $sformatf("pop %0d/%0d top %0d/%0d cnt %0d drop %0d", r.popped_note,
                       r.popped_velocity, r.top_note, r.top_velocity, r.held_count,
                       r.push_dropped);
   endfunction

   // last-note priority stack: slot 0 oldest, held_level-1 newest
   function automatic stack_report_t apply_stack_cmd(cmd_type cmd, note_type note,
                                                     note_type vel);
      stack_report_t r;
      int            hit;
      int            i;
      r   = '0;
      hit = -1;
      case (cmd)
         CMD_PUSH: begin
            if (note != 0) begin
               if (held_level >= DEPTH) begin
                  r.push_dropped = 1'b1;
               end else begin
                  held_notes[held_level] = note;
                  held_vels[held_level]  = vel;
                  held_level++;
               end
            end
         end
         CMD_ERASE: begin
            for (i = 0; i < held_level; i++) begin
               if (hit < 0 && held_notes[i] == note) hit = i;
            end
            if (hit >= 0) begin
               for (i = hit; i < held_level - 1; i++) begin
                  held_notes[i] = held_notes[i + 1];
                  held_vels[i]  = held_vels[i + 1];
               end
               held_level--;
            end
         end
         CMD_POP: begin
            if (held_level > 0) begin
               r.popped_note     = held_notes[held_level - 1];
               r.popped_velocity = held_vels[held_level - 1];
               held_level--;
            end
         end
         default: begin
         end
      endcase
      if (held_level > 0) begin
         r.top_note     = held_notes[held_level - 1];
         r.top_velocity = held_vels[held_level - 1];
      end
      r.held_count = COUNT_W'(held_level);
      return r;
   endfunction

   task automatic log_failure(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("mismatch: %s", msg);
   endtask

   task automatic check_report(logic [RSP_W-1:0] beat);
      stack_report_t got;
      stack_report_t want;
      got = stack_report_t'(beat[REPORT_W-1:0]);
      if (expected_reports.size() == 0) begin
         log_failure($sformatf("unexpected beat %h", beat));
      end else begin
         want = expected_reports.pop_front();
         if (got.popped_note !== want.popped_note ||
             got.popped_velocity !== want.popped_velocity ||
             got.top_note !== want.top_note ||
             got.top_velocity !== want.top_velocity ||
             got.held_count !== want.held_count ||
             got.push_dropped !== want.push_dropped ||
             beat[RSP_W-1:REPORT_W] !== '0) begin
            log_failure($sformatf("expected %s, got %s pad %h", show(want), show(got),
                                  beat[RSP_W-1:REPORT_W]));
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) check_report(rsp_tdata);
   end

   task automatic drive_beat(cmd_type cmd, note_type note, note_type vel, bit typed,
                             stack_report_t typed_report);
      stack_report_t predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {vel, note, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = apply_stack_cmd(cmd, note, vel);
      expected_reports.push_back(typed ? typed_report : predicted);
   endtask

   task automatic wait_for_reports();
      req_tvalid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
   endtask

   task automatic pick_random(output cmd_type cmd, output note_type note,
                              output note_type vel);
      int roll;
      roll = $urandom_range(99);
      if ($urandom_range(39) == 0) filling = !filling;
      vel  = note_type'($urandom_range(127));
      note = ($urandom_range(1) == 0) ? note_type'($urandom_range(8, 1))
                                      : note_type'($urandom_range(127, 1));
      if (roll < 5) begin
         cmd     = CMD_PUSH;
         note    = '0;
      end else if (roll < 9) begin
         cmd     = CMD_NOP;
      end else if (roll < (filling ? 75 : 24)) begin
         cmd = CMD_PUSH;
      end else if (roll < (filling ? 90 : 70)) begin
         cmd = CMD_ERASE;
         if (held_level > 0 && $urandom_range(99) < 80)
            note = held_notes[$urandom_range(held_level - 1)];
      end else begin
         cmd = CMD_POP;
      end
   endtask

   initial begin
      stack_report_t none;
      cmd_type       cmd;
      note_type      note;
      note_type      vel;
      int            done;
      int            r;
      int            k;
      int            phase;
      none = '0;

      // typed rows: empty stack, first pushes, full-stack drop
      directed_rows.push_back('{CMD_PUSH,  7'd0,   7'd5,   1,  1'b1, none});
      directed_rows.push_back('{CMD_POP,   7'd0,   7'd0,   1,  1'b1, none});
      directed_rows.push_back('{CMD_ERASE, 7'd9,   7'd0,   1,  1'b1, none});
      directed_rows.push_back('{CMD_NOP,   7'd127, 7'd127, 1,  1'b1, none});
      directed_rows.push_back('{CMD_PUSH,  7'd127, 7'd127, 1,  1'b1,
                                make_report(0, 0, 127, 127, 1, 0)});
      directed_rows.push_back('{CMD_PUSH,  7'd1,   7'd0,   1,  1'b1,
                                make_report(0, 0, 1, 0, 2, 0)});
      directed_rows.push_back('{CMD_PUSH,  7'd127, 7'd3,   1,  1'b0, none});
      directed_rows.push_back('{CMD_ERASE, 7'd127, 7'd0,   1,  1'b0, none});
      directed_rows.push_back('{CMD_ERASE, 7'd55,  7'd0,   1,  1'b0, none});
      directed_rows.push_back('{CMD_ERASE, 7'd0,   7'd0,   1,  1'b0, none});
      directed_rows.push_back('{CMD_POP,   7'd0,   7'd0,   2,  1'b0, none});
      directed_rows.push_back('{CMD_POP,   7'd0,   7'd0,   1,  1'b1, none});
      directed_rows.push_back('{CMD_PUSH,  7'd100, 7'd42,  16, 1'b0, none});
      directed_rows.push_back('{CMD_PUSH,  7'd9,   7'd9,   1,  1'b1,
                                make_report(0, 0, 115, 57, 16, 1)});
      directed_rows.push_back('{CMD_PUSH,  7'd0,   7'd1,   1,  1'b0, none});
      directed_rows.push_back('{CMD_NOP,   7'd5,   7'd5,   1,  1'b0, none});
      directed_rows.push_back('{CMD_ERASE, 7'd100, 7'd0,   1,  1'b0, none});
      directed_rows.push_back('{CMD_ERASE, 7'd115, 7'd0,   1,  1'b0, none});
      directed_rows.push_back('{CMD_ERASE, 7'd107, 7'd0,   1,  1'b0, none});
      directed_rows.push_back('{CMD_PUSH,  7'd107, 7'd127, 1,  1'b0, none});
      directed_rows.push_back('{CMD_POP,   7'd0,   7'd0,   16, 1'b0, none});

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (r = 0; r < directed_rows.size(); r++) begin
         for (k = 0; k < directed_rows[r].rep; k++) begin
            drive_beat(directed_rows[r].cmd, note_type'(directed_rows[r].note + k),
                       note_type'(directed_rows[r].velocity + k), directed_rows[r].typed,
                       directed_rows[r].report);
         end
      end
      wait_for_reports();

      done = 0;
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 80;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 80;
            end
            default: begin
               send_idle_pct  = 34;
               recv_stall_pct = 34;
            end
         endcase
         while (done < (phase + 1) * ITEMS / 4) begin
            pick_random(cmd, note, vel);
            drive_beat(cmd, note, vel, 1'b0, none);
            done++;
         end
         wait_for_reports();
      end

      repeat (SETTLE) @(posedge clock);
      if (expected_reports.size() != 0) log_failure("results still outstanding");
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/nps_pkg.sv
rtl/nps_ram.sv
rtl/note_priority_stack_core.sv
verif/tb_note_priority_stack_core.sv
